// ----- design/bss_pkg.sv -----
// Shared types and constants of the bass step sequencer.
`default_nettype none

package bss_pkg;

    localparam int ADDR_W = 4;

    // Register map, word index taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_TUNE_OFFSET   = 2'd0,
        REG_SWING_TICK    = 2'd1,
        REG_SWING_ENABLE  = 2'd2,
        REG_QUEUED_LENGTH = 2'd3
    } reg_idx_t;

    // Request codes
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_TOGGLE = 1'b1;

    localparam logic signed [5:0] TUNE_RESET   = 6'sd0;
    localparam logic [4:0]        SWING_RESET  = 5'd12;
    localparam logic [5:0]        LENGTH_RESET = 6'd16;

    localparam logic [7:0] BASE_NOTE     = 8'd40;
    localparam logic [4:0] TICKS_PER_BT  = 5'd24;
    localparam logic [4:0] STRAIGHT_TICK = 5'd12;
    localparam logic signed [6:0] GATE_OFF_A = 7'sd6;
    localparam logic signed [6:0] GATE_OFF_B = 7'sd18;
    localparam logic [14:0] PITCH_MAX    = 15'h7fff;

    // x*256/11 as (x*RECIP_11) >> RECIP_SHIFT, exact for x up to 63
    localparam logic [12:0] RECIP_11    = 13'd5958;
    localparam int          RECIP_SHIFT = 8;

    typedef struct packed {
        logic       req_type;
        logic [5:0] step_note;
        logic       step_rest;
        logic       step_slide;
        logic       step_accent;
    } req_t;

    typedef struct packed {
        logic        gate;
        logic [14:0] pitch;
        logic        accent;
        logic [4:0]  fetch_index;
        logic        running;
    } rsp_t;

endpackage

`default_nettype wire

// ----- design/bass_step_sequencer.sv -----
// Top level of the bass step sequencer: config registers, step state and result register.
`default_nettype none

// Bass step sequencer, 24 ticks per beat. One word enters per clock: the whole
// state update for a tick or a start/stop word is done in the cycle it is
// accepted, and its result lands in an output register, so the sustained rate
// is one word per cycle while out_ready stays high. in_ready drops only while
// the output register holds a word that is not being taken. A playing tick and
// a stop each produce one result word; a start and a tick while stopped
// produce none. The host supplies on every tick the fields of the step named
// by the last result's fetch_index. Configuration goes through the APB port
// (word 0 tune, 1 swing tick, 2 swing enable, 3 queued length) and should be
// written while no word is in flight.
module bass_step_sequencer #(
    parameter int MAX_STEPS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire bss_pkg::req_t              in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output bss_pkg::rsp_t                   out_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bss_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bss_pkg::*;

    localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    // Configuration
    logic signed [5:0] tune_offset_reg;
    logic [4:0]        swing_tick_reg;
    logic              swing_enable_reg;
    logic [5:0]        queued_length_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;

    // Sequencer state
    logic                     running_reg, running_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [4:0]               tick_reg, tick_next;
    logic                     trig_reg, trig_next;
    logic                     swung_reg, swung_next;
    logic signed [11:0]       rate_reg, rate_next;
    logic [14:0]              pitch_reg, pitch_next;
    logic                     gate_reg, gate_next;
    logic                     accent_reg, accent_next;
    logic [5:0]               prev_note_reg, prev_note_next;
    logic                     prev_slides_reg, prev_slides_next;
    logic [5:0]               active_len_reg, active_len_next;

    logic out_valid_reg;
    rsp_t out_data_reg;

    logic accept;
    logic emit;
    logic rest;
    logic slides;
    logic fire;

    logic [14:0]        tgt_note;
    logic [14:0]        tgt_prev;
    logic signed [6:0]  note_diff;
    logic [5:0]         diff_mag;
    logic [18:0]        rate_prod;
    logic [10:0]        rate_mag;
    logic signed [11:0] rate_calc;
    logic [14:0]        pitch_base;
    logic signed [11:0] rate_cur;
    logic signed [16:0] pitch_sum;
    logic [14:0]        pitch_sat;
    logic [14:0]        pitch_new;

    logic [4:0]         tick_inc;
    logic [4:0]         s_tick;
    logic signed [6:0]  swing_shift;
    logic signed [6:0]  tick_s;
    logic               gate_off;
    logic               beat;
    logic               offbeat;
    logic               advance;
    logic [STEP_W:0]    step_inc;
    logic               wrap;

    function automatic logic [14:0] target_pitch(input logic [5:0] n,
                                                 input logic signed [5:0] tune);
        logic signed [8:0] s;
        begin
            s = $signed({1'b0, BASE_NOTE}) + $signed({3'b000, n}) + 9'(tune);
            if (s < 0)
                target_pitch = '0;
            else if (s > 9'sd127)
                target_pitch = PITCH_MAX;
            else
                target_pitch = {s[6:0], 8'h00};
        end
    endfunction

    // ---------------- APB register port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_TUNE_OFFSET:   prdata = 32'(tune_offset_reg);
            REG_SWING_TICK:    prdata = {27'd0, swing_tick_reg};
            REG_SWING_ENABLE:  prdata = {31'd0, swing_enable_reg};
            REG_QUEUED_LENGTH: prdata = {26'd0, queued_length_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tune_offset_reg   <= TUNE_RESET;
            swing_tick_reg    <= SWING_RESET;
            swing_enable_reg  <= 1'b0;
            queued_length_reg <= LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_TUNE_OFFSET:   tune_offset_reg   <= $signed(pwdata[5:0]);
                REG_SWING_TICK:    swing_tick_reg    <= pwdata[4:0];
                REG_SWING_ENABLE:  swing_enable_reg  <= pwdata[0];
                REG_QUEUED_LENGTH: queued_length_reg <= pwdata[5:0];
                default:           ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign rest   = in_data.step_rest;
    assign slides = in_data.step_slide && !rest;
    assign fire   = trig_reg && !rest;

    // ---------------- pitch path ----------------
    assign tgt_note = target_pitch(in_data.step_note, tune_offset_reg);
    assign tgt_prev = target_pitch(prev_note_reg, tune_offset_reg);

    assign note_diff = $signed({1'b0, in_data.step_note}) - $signed({1'b0, prev_note_reg});
    assign diff_mag  = note_diff[6] ? 6'(-note_diff) : note_diff[5:0];
    assign rate_prod = 19'(diff_mag) * 19'(RECIP_11);
    assign rate_mag  = rate_prod[RECIP_SHIFT +: 11];
    // truncate toward zero: negate the magnitude
    assign rate_calc = note_diff[6] ? -$signed({1'b0, rate_mag}) : $signed({1'b0, rate_mag});

    always_comb
    begin
        if (fire && prev_slides_reg)
        begin
            pitch_base = tgt_prev;
            rate_cur   = rate_calc;
        end
        else if (fire)
        begin
            pitch_base = tgt_note;
            rate_cur   = '0;
        end
        else
        begin
            pitch_base = pitch_reg;
            rate_cur   = rate_reg;
        end
    end

    assign pitch_sum = $signed({2'b00, pitch_base}) + 17'(rate_cur);

    always_comb
    begin
        if (pitch_sum < 0)
            pitch_sat = '0;
        else if (pitch_sum > $signed({2'b00, PITCH_MAX}))
            pitch_sat = PITCH_MAX;
        else
            pitch_sat = pitch_sum[14:0];

        // clamp the glide at the target note
        if (rate_cur > 0 && pitch_sat > tgt_note)
            pitch_new = tgt_note;
        else if (rate_cur < 0 && pitch_sat < tgt_note)
            pitch_new = tgt_note;
        else
            pitch_new = pitch_sat;
    end

    // ---------------- tick and step path ----------------
    assign tick_inc    = tick_reg + 5'd1;
    assign s_tick      = swing_enable_reg ? swing_tick_reg : STRAIGHT_TICK;
    assign swing_shift = swing_enable_reg ? ($signed({2'b00, swing_tick_reg})
                                             - $signed({2'b00, STRAIGHT_TICK})) : 7'sd0;
    assign tick_s      = $signed({2'b00, tick_inc});
    assign gate_off    = !slides && (tick_s == GATE_OFF_A - swing_shift
                                     || tick_s == GATE_OFF_B + swing_shift);
    assign beat        = (tick_inc == TICKS_PER_BT);
    assign offbeat     = !beat && (tick_inc >= s_tick) && !swung_reg;
    assign advance     = beat || offbeat;
    assign step_inc    = {1'b0, step_reg} + (STEP_W+1)'(advance);
    assign wrap        = (7'(step_inc) >= {1'b0, active_len_reg})
                         || (32'(step_inc) >= 32'(MAX_STEPS));

    always_comb
    begin
        running_next     = running_reg;
        step_next        = step_reg;
        tick_next        = tick_reg;
        trig_next        = trig_reg;
        swung_next       = swung_reg;
        rate_next        = rate_reg;
        pitch_next       = pitch_reg;
        gate_next        = gate_reg;
        accent_next      = accent_reg;
        prev_note_next   = prev_note_reg;
        prev_slides_next = prev_slides_reg;
        active_len_next  = active_len_reg;
        emit             = 1'b0;

        if (accept)
        begin
            if (in_data.req_type == REQ_TOGGLE)
            begin
                active_len_next = queued_length_reg;
                if (running_reg)
                begin
                    running_next     = 1'b0;
                    step_next        = '0;
                    tick_next        = '0;
                    trig_next        = 1'b0;
                    swung_next       = 1'b0;
                    rate_next        = '0;
                    gate_next        = 1'b0;
                    prev_note_next   = '0;
                    prev_slides_next = 1'b0;
                    emit             = 1'b1;
                end
                else
                begin
                    running_next = 1'b1;
                    trig_next    = 1'b1;
                end
            end
            else if (running_reg)
            begin
                emit       = 1'b1;
                rate_next  = rate_cur;
                pitch_next = pitch_new;
                if (fire)
                begin
                    trig_next = 1'b0;
                    gate_next = 1'b1;
                    if (!prev_slides_reg)
                        accent_next = in_data.step_accent;
                end
                if (gate_off)
                    gate_next = 1'b0;

                tick_next = beat ? 5'd0 : tick_inc;
                if (beat)
                    swung_next = 1'b0;
                else if (offbeat)
                    swung_next = 1'b1;

                if (advance)
                begin
                    trig_next        = 1'b1;
                    prev_note_next   = in_data.step_note;
                    prev_slides_next = slides;
                end
                step_next = step_inc[STEP_W-1:0];

                if (wrap)
                begin
                    trig_next       = 1'b1;
                    active_len_next = queued_length_reg;
                    step_next       = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= 1'b0;
            step_reg        <= '0;
            tick_reg        <= '0;
            trig_reg        <= 1'b0;
            swung_reg       <= 1'b0;
            rate_reg        <= '0;
            pitch_reg       <= '0;
            gate_reg        <= 1'b0;
            accent_reg      <= 1'b0;
            prev_note_reg   <= '0;
            prev_slides_reg <= 1'b0;
            active_len_reg  <= LENGTH_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            running_reg     <= running_next;
            step_reg        <= step_next;
            tick_reg        <= tick_next;
            trig_reg        <= trig_next;
            swung_reg       <= swung_next;
            rate_reg        <= rate_next;
            pitch_reg       <= pitch_next;
            gate_reg        <= gate_next;
            accent_reg      <= accent_next;
            prev_note_reg   <= prev_note_next;
            prev_slides_reg <= prev_slides_next;
            active_len_reg  <= active_len_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result word, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.gate        <= gate_next;
            out_data_reg.pitch       <= pitch_next;
            out_data_reg.accent      <= accent_next;
            out_data_reg.fetch_index <= 5'(step_next);
            out_data_reg.running     <= running_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- design/bss_checker.sv -----
// Port-level checker for the bass step sequencer and its bind.
`default_nettype none

module bss_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire bss_pkg::req_t in_data,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire bss_pkg::rsp_t out_data
);
    import bss_pkg::*;

    // hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // an empty output register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // a stopped word carries a closed gate and the first step
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.running |-> !out_data.gate && out_data.fetch_index == 5'd0)
        else $error("stop word with open gate or nonzero step");

    // a toggle taken with the output register empty yields no running result word in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.req_type == REQ_TOGGLE && !out_valid
        ##1 out_valid |-> !out_data.running)
        else $error("toggle produced a running result word");

endmodule

bind bass_step_sequencer bss_checker u_bss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ----- sim/bass_step_sequencer_tb.sv -----
// Testbench for the bass step sequencer: directed steps, then randomized patterns per phase.
`timescale 1ns / 1ps

module bass_step_sequencer_tb;

    import bss_pkg::*;

    localparam int STEP_LIMIT = 32;
    localparam int PHASE_WORDS = 250;
    localparam int PHASE_COUNT = 8;
    localparam int DIR_ROWS = 25;

    typedef struct packed {
        req_t word;
        logic pin;
        rsp_t want;
    } dir_row_t;

    typedef struct packed {
        logic       rnd;
        logic [5:0] tune;
        logic [4:0] stick;
        logic       sen;
        logic [5:0] qlen;
        logic [6:0] idle_pct;
        logic [6:0] stall_pct;
    } phase_t;

    localparam rsp_t NO_PIN = '0;

    // Start, first trigger, stop, rest holding the trigger, slide into a glide,
    // rest clamping the glide, stop, ticks while stopped
    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b0, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TOGGLE, 6'd0,  1'b0, 1'b0, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd63, 1'b0, 1'b0, 1'b1}, 1'b1, '{1'b1, 15'd26368, 1'b1, 5'd0, 1'b1}},
        '{'{REQ_TOGGLE, 6'd0,  1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 15'd26368, 1'b1, 5'd0, 1'b0}},
        '{'{REQ_TICK,   6'd63, 1'b1, 1'b1, 1'b1}, 1'b0, NO_PIN},
        '{'{REQ_TOGGLE, 6'd0,  1'b0, 1'b0, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd5,  1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 15'd26368, 1'b1, 5'd0, 1'b1}},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b0, 1'b0}, 1'b1, '{1'b1, 15'd10240, 1'b0, 5'd0, 1'b1}},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b1, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd63, 1'b0, 1'b0, 1'b1}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd63, 1'b0, 1'b0, 1'b1}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd63, 1'b0, 1'b0, 1'b1}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd63, 1'b0, 1'b1, 1'b1}, 1'b0, NO_PIN},
        '{'{REQ_TOGGLE, 6'd0,  1'b0, 1'b0, 1'b0}, 1'b0, NO_PIN},
        '{'{REQ_TICK,   6'd0,  1'b0, 1'b0, 1'b0}, 1'b0, NO_PIN}
    };

    localparam phase_t PHASES [0:PHASE_COUNT-1] = '{
        '{1'b0, 6'(-24), 5'd12, 1'b0, 6'd16, 7'd0,  7'd0},
        '{1'b0, 6'd24,   5'd23, 1'b1, 6'd1,  7'd77, 7'd0},
        '{1'b0, 6'd31,   5'd31, 1'b1, 6'd32, 7'd0,  7'd77},
        '{1'b0, 6'(-32), 5'd0,  1'b1, 6'd0,  7'd34, 7'd34},
        '{1'b0, 6'd5,    5'd17, 1'b1, 6'd63, 7'd0,  7'd0},
        '{1'b0, 6'(-7),  5'd12, 1'b0, 6'd33, 7'd0,  7'd77},
        '{1'b1, 6'd0,    5'd0,  1'b0, 6'd0,  7'd77, 7'd0},
        '{1'b1, 6'd0,    5'd0,  1'b0, 6'd0,  7'd34, 7'd34}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    req_t        in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    rsp_t        out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Pinned expectation traveling with the word on the input channel
    logic        pin_flag = 1'b0;
    rsp_t        pin_word = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    rsp_t due_words [$];

    // Sequencer state as seen from outside
    logic signed [5:0]  tune_q = TUNE_RESET;
    logic [4:0]         swing_tick_q = SWING_RESET;
    logic               swing_en_q = 1'b0;
    logic [5:0]         queued_q = LENGTH_RESET;
    logic               playing = 1'b0;
    logic [5:0]         step_q = '0;
    logic [4:0]         ticks = '0;
    logic               trig = 1'b0;
    logic               swung = 1'b0;
    logic signed [15:0] glide = '0;
    logic [14:0]        pitch_q = '0;
    logic               gate_q = 1'b0;
    logic               acc_q = 1'b0;
    logic [5:0]         prev_note = '0;
    logic               prev_slides = 1'b0;
    logic [5:0]         act_len = LENGTH_RESET;

    bass_step_sequencer #(.MAX_STEPS(STEP_LIMIT)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [14:0] note_pitch(input logic [5:0] note);
        int v;
        v = (int'(BASE_NOTE) + int'(tune_q) + int'(note)) * 256;
        if (v < 0)
            v = 0;
        else if (v > int'(PITCH_MAX))
            v = int'(PITCH_MAX);
        return 15'(v);
    endfunction

    function automatic rsp_t seq_word();
        rsp_t r;
        r.gate = gate_q;
        r.pitch = pitch_q;
        r.accent = acc_q;
        r.fetch_index = step_q[4:0];
        r.running = playing;
        return r;
    endfunction

    // Apply one accepted word to the sequencer state; return 1 if it yields a result word
    function automatic bit advance_sequencer(input req_t w, output rsp_t r);
        logic slides;
        int   tgt;
        int   p;
        int   s_tick;
        int   ns;
        slides = w.step_slide && !w.step_rest;
        r = '0;
        if (w.req_type == REQ_TOGGLE)
        begin
            act_len = queued_q;
            if (playing)
            begin
                playing = 1'b0;
                prev_note = '0;
                prev_slides = 1'b0;
                step_q = '0;
                ticks = '0;
                glide = '0;
                gate_q = 1'b0;
                trig = 1'b0;
                swung = 1'b0;
                r = seq_word();
                return 1'b1;
            end
            playing = 1'b1;
            trig = 1'b1;
            return 1'b0;
        end
        if (!playing)
            return 1'b0;

        if (trig && !w.step_rest)
        begin
            trig = 1'b0;
            glide = '0;
            gate_q = 1'b1;
            if (prev_slides)
            begin
                pitch_q = note_pitch(prev_note);
                glide = 16'(((int'(w.step_note) - int'(prev_note)) * 256) / 11);
            end
            else
            begin
                pitch_q = note_pitch(w.step_note);
                acc_q = w.step_accent;
            end
        end

        // Glide toward the step's note, never past it
        tgt = int'(note_pitch(w.step_note));
        p = int'(pitch_q) + int'(glide);
        if (p < 0)
            p = 0;
        else if (p > int'(PITCH_MAX))
            p = int'(PITCH_MAX);
        if (glide > 0 && p > tgt)
            p = tgt;
        else if (glide < 0 && p < tgt)
            p = tgt;
        pitch_q = 15'(p);

        s_tick = swing_en_q ? int'(swing_tick_q) : int'(STRAIGHT_TICK);
        ns = swing_en_q ? s_tick - int'(STRAIGHT_TICK) : 0;

        ticks = ticks + 5'd1;
        if (!slides && (int'(ticks) == int'(GATE_OFF_A) - ns ||
                        int'(ticks) == int'(GATE_OFF_B) + ns))
            gate_q = 1'b0;

        if (ticks == TICKS_PER_BT)
        begin
            swung = 1'b0;
            trig = 1'b1;
            ticks = '0;
            step_q = step_q + 6'd1;
            prev_note = w.step_note;
            prev_slides = slides;
        end
        else if (int'(ticks) >= s_tick && !swung)
        begin
            swung = 1'b1;
            trig = 1'b1;
            step_q = step_q + 6'd1;
            prev_note = w.step_note;
            prev_slides = slides;
        end

        // Wrap into the queued pattern
        if (step_q >= act_len || int'(step_q) >= STEP_LIMIT)
        begin
            trig = 1'b1;
            act_len = queued_q;
            step_q = '0;
        end

        r = seq_word();
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : watch
        rsp_t want;
        rsp_t got;
        rsp_t calc;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (due_words.size() == 0)
                begin
                    $display("%0t: result word with none expected, got %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = due_words.pop_front();
                    if (got.gate !== want.gate)
                    begin
                        $display("%0t: gate expected %0d, got %0d", $time, want.gate, got.gate);
                        fail_count++;
                    end
                    if (got.pitch !== want.pitch)
                    begin
                        $display("%0t: pitch expected %0d, got %0d",
                                 $time, want.pitch, got.pitch);
                        fail_count++;
                    end
                    if (got.accent !== want.accent)
                    begin
                        $display("%0t: accent expected %0d, got %0d",
                                 $time, want.accent, got.accent);
                        fail_count++;
                    end
                    if (got.fetch_index !== want.fetch_index)
                    begin
                        $display("%0t: fetch_index expected %0d, got %0d",
                                 $time, want.fetch_index, got.fetch_index);
                        fail_count++;
                    end
                    if (got.running !== want.running)
                    begin
                        $display("%0t: running expected %0d, got %0d",
                                 $time, want.running, got.running);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (advance_sequencer(in_data, calc))
                    due_words.push_back(pin_flag ? pin_word : calc);
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Present one word from a falling edge, holding it until the block takes it
    task automatic offer(input req_t w, input logic pin, input rsp_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        pin_flag <= pin;
        pin_word <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every expected word is out
    task automatic settle_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_TUNE_OFFSET:   tune_q = val[5:0];
            REG_SWING_TICK:    swing_tick_q = val[4:0];
            REG_SWING_ENABLE:  swing_en_q = val[0];
            REG_QUEUED_LENGTH: queued_q = val[5:0];
            default:           ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : stim
        phase_t ph;
        req_t   w;
        req_t   pattern [0:31];
        logic   counted;
        int     n;
        int     pi;
        int     k;
        int     r;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
        begin
            @(negedge clk);
            offer(DIR_TAB[k].word, DIR_TAB[k].pin, DIR_TAB[k].want);
        end
        settle_results();

        for (pi = 0; pi < PHASE_COUNT; pi++)
        begin
            ph = PHASES[pi];
            if (ph.rnd)
            begin
                ph.tune = 6'($urandom);
                ph.stick = 5'($urandom);
                ph.sen = 1'($urandom);
                ph.qlen = 6'($urandom);
            end
            write_reg(REG_TUNE_OFFSET, {26'd0, ph.tune});
            write_reg(REG_SWING_TICK, {27'd0, ph.stick});
            write_reg(REG_SWING_ENABLE, {31'd0, ph.sen});
            write_reg(REG_QUEUED_LENGTH, {26'd0, ph.qlen});

            for (k = 0; k < 32; k++)
            begin
                pattern[k].req_type = REQ_TICK;
                if ($urandom_range(7) == 0)
                    pattern[k].step_note = $urandom_range(1) ? 6'd63 : 6'd0;
                else
                    pattern[k].step_note = 6'($urandom_range(63));
                pattern[k].step_rest = ($urandom_range(4) == 0);
                pattern[k].step_slide = ($urandom_range(2) == 0);
                pattern[k].step_accent = 1'($urandom_range(1));
            end

            idle_pct = int'(ph.idle_pct);
            stall_pct = int'(ph.stall_pct);
            n = 0;
            while (n < PHASE_WORDS)
            begin
                // Pick the next word once the last accepted one is in the state
                @(negedge clk);
                w = 10'($urandom);
                counted = 1'b1;
                if (!playing)
                begin
                    // Mostly start again; now and then a tick that the block ignores
                    if ($urandom_range(15) == 0)
                    begin
                        w.req_type = REQ_TICK;
                        counted = 1'b0;
                    end
                    else
                        w.req_type = REQ_TOGGLE;
                end
                else
                begin
                    r = $urandom_range(199);
                    if (r == 0)
                        w.req_type = REQ_TOGGLE;
                    else if (r < 15)
                        w.req_type = REQ_TICK;
                    else
                        w = pattern[step_q[4:0]];
                end
                offer(w, 1'b0, NO_PIN);
                if (counted)
                begin
                    n++;
                    if (pi == 2 && n == PHASE_WORDS / 2)
                        settle_results();
                end
            end
            settle_results();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
